// ===== src/tsiir_pkg.sv =====
`timescale 1ns / 1ps

package tsiir_pkg;

    localparam int AXES = 3;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int COEF_WIDTH = 32;
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS = 16;
    localparam int COEF_FRAC_BITS = 30;
    localparam int PROD_WIDTH = DATA_WIDTH + COEF_WIDTH;
    localparam int SUM_WIDTH = PROD_WIDTH + 2;
    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic signed [COEF_WIDTH-1:0] FB_ONE_RESET = 32'sd2071735500;
    localparam logic signed [COEF_WIDTH-1:0] FB_TWO_RESET = -32'sd1000494913;
    localparam logic signed [COEF_WIDTH-1:0] INPUT_RESET = 32'sd2501237;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_FB_ONE = 2'd0,
        REG_FB_TWO = 2'd1,
        REG_INPUT  = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] fb_one;
        logic signed [COEF_WIDTH-1:0] fb_two;
        logic signed [COEF_WIDTH-1:0] gain;
    } coef_t;

    typedef struct packed {
        logic load;
        logic primed;
    } axis_ctrl_t;

    typedef logic signed [DATA_WIDTH-1:0] q16_t;

    function automatic q16_t sat_q16(input logic signed [SUM_WIDTH-1:0] v);
        q16_t max_v;
        q16_t min_v;
        max_v = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        min_v = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        if (v > SUM_WIDTH'(max_v))
        begin
            return max_v;
        end
        else if (v < SUM_WIDTH'(min_v))
        begin
            return min_v;
        end
        return v[DATA_WIDTH-1:0];
    endfunction

endpackage

// ===== src/tsiir_sample_if.sv =====
`timescale 1ns / 1ps

interface tsiir_sample_if #(
    parameter int SAMPLE_WIDTH = tsiir_pkg::SAMPLE_WIDTH_DEF
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_x;
    logic signed [SAMPLE_WIDTH-1:0] sample_y;
    logic signed [SAMPLE_WIDTH-1:0] sample_z;

    modport source (output valid, output sample_x, output sample_y, output sample_z,
                    input ready);
    modport sink (input valid, input sample_x, input sample_y, input sample_z,
                  output ready);
endinterface

// ===== src/tsiir_result_if.sv =====
`timescale 1ns / 1ps

interface tsiir_result_if ();
    logic               valid;
    logic               ready;
    logic signed [31:0] filtered_x;
    logic signed [31:0] filtered_y;
    logic signed [31:0] filtered_z;

    modport source (output valid, output filtered_x, output filtered_y,
                    output filtered_z, input ready);
    modport sink (input valid, input filtered_x, input filtered_y, input filtered_z,
                  output ready);
endinterface

// ===== src/tsiir_coef_regs.sv =====
`timescale 1ns / 1ps

module tsiir_coef_regs (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [tsiir_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [tsiir_pkg::COEF_WIDTH-1:0]      cfg_data,
    output tsiir_pkg::coef_t                      coefs
);
    import tsiir_pkg::*;

    coef_t coef_reg;
    coef_t coef_next;

    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_FB_ONE: coef_next.fb_one = cfg_data;
                REG_FB_TWO: coef_next.fb_two = cfg_data;
                REG_INPUT:  coef_next.gain   = cfg_data;
                default:    coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.fb_one <= FB_ONE_RESET;
            coef_reg.fb_two <= FB_TWO_RESET;
            coef_reg.gain   <= INPUT_RESET;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign coefs = coef_reg;

endmodule

// ===== src/tsiir_axis.sv =====
`timescale 1ns / 1ps

module tsiir_axis #(
    parameter int SAMPLE_WIDTH = tsiir_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tsiir_pkg::axis_ctrl_t          ctrl,
    input  tsiir_pkg::coef_t               coefs,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    output tsiir_pkg::q16_t                filtered
);
    import tsiir_pkg::*;

    q16_t last_reg;
    q16_t last_next;
    q16_t before_reg;
    q16_t before_next;

    logic signed [SUM_WIDTH-1:0]  sample_wide;
    q16_t                         sample_q;
    logic signed [PROD_WIDTH-1:0] prod_one;
    logic signed [PROD_WIDTH-1:0] prod_two;
    logic signed [PROD_WIDTH-1:0] prod_in;
    logic signed [SUM_WIDTH-1:0]  sum;
    logic signed [SUM_WIDTH-1:0]  round_half;
    q16_t                         filt;
    q16_t                         y;

    // The three products are summed exactly, a half LSB of Q16.16 is added,
    // and the arithmetic shift floors the sum before saturation.
    always_comb
    begin
        sample_wide = SUM_WIDTH'(sample) <<< FRAC_BITS;
        sample_q    = sat_q16(sample_wide);
        prod_one    = PROD_WIDTH'(last_reg) * PROD_WIDTH'(coefs.fb_one);
        prod_two    = PROD_WIDTH'(before_reg) * PROD_WIDTH'(coefs.fb_two);
        prod_in     = PROD_WIDTH'(sample_q) * PROD_WIDTH'(coefs.gain);
        round_half  = SUM_WIDTH'(1) <<< (COEF_FRAC_BITS - 1);
        sum         = SUM_WIDTH'(prod_one) + SUM_WIDTH'(prod_two)
                    + SUM_WIDTH'(prod_in) + round_half;
        filt        = sat_q16(sum >>> COEF_FRAC_BITS);
        y           = ctrl.primed ? filt : sample_q;

        last_next   = last_reg;
        before_next = before_reg;
        if (ctrl.load)
        begin
            last_next   = y;
            before_next = ctrl.primed ? last_reg : sample_q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg   <= '0;
            before_reg <= '0;
        end
        else
        begin
            last_reg   <= last_next;
            before_reg <= before_next;
        end
    end

    assign filtered = y;

endmodule

// ===== src/three_axis_second_order_iir_lowpass_top.sv =====
`timescale 1ns / 1ps

// Three-axis second-order IIR low-pass filter.
// The samples channel carries one signed raw sample per axis in each transaction;
// the results channel returns one transaction per sample transaction, holding the
// three filtered values in signed Q16.16, saturated to 32 bits.
// Both channels use a valid/ready handshake; a transaction completes on a rising
// edge of clk with valid and ready high.
// The coefficients are written through cfg_write, cfg_index and cfg_data in Q2.30
// and should only be changed while no transactions are in flight.
// An accepted sample enters an input register; the filter arithmetic for all three
// axes is combinational from that register and is loaded into the result register
// as the sample advances, which waits while a held result occupies that register.
// Throughput is one sample per cycle while results ready stays high, since the
// per-axis output history that each sample depends on is updated as it advances.
// Reset clears the history, the priming flag and the valid flags of both pipeline
// stages, and loads the default coefficients. The first sample after reset passes
// through unchanged and seeds the history.
// When the receiver holds ready low, the result register keeps its transaction and
// the input register keeps one more; samples ready then falls until space frees up.
module three_axis_second_order_iir_lowpass_top #(
    parameter int SAMPLE_WIDTH = tsiir_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    tsiir_sample_if.sink                          samples,
    tsiir_result_if.source                        results,
    input  logic                                  cfg_write,
    input  logic [tsiir_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [tsiir_pkg::COEF_WIDTH-1:0]      cfg_data
);
    import tsiir_pkg::*;

    coef_t      coefs;
    axis_ctrl_t ctrl;

    logic in_valid_reg;
    logic in_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic primed_reg;
    logic primed_next;
    logic take_in;
    logic advance;

    logic signed [SAMPLE_WIDTH-1:0] sample_reg [AXES];
    logic signed [SAMPLE_WIDTH-1:0] sample_next [AXES];
    q16_t                           result_reg [AXES];
    q16_t                           filtered [AXES];

    tsiir_coef_regs u_coef_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coefs     (coefs)
    );

    assign advance = in_valid_reg && (!out_valid_reg || results.ready);
    assign samples.ready = !in_valid_reg || advance;
    assign take_in = samples.valid && samples.ready;

    assign ctrl.load   = advance;
    assign ctrl.primed = primed_reg;

    generate
        for (genvar a = 0; a < AXES; a++)
        begin : g_axis
            tsiir_axis #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH)
            ) u_axis (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .coefs    (coefs),
                .sample   (sample_reg[a]),
                .filtered (filtered[a])
            );
        end
    endgenerate

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        primed_next    = primed_reg || advance;
        sample_next[0] = samples.sample_x;
        sample_next[1] = samples.sample_y;
        sample_next[2] = samples.sample_z;
        if (take_in)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            primed_reg    <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            primed_reg    <= primed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            sample_reg <= sample_next;
        end
        if (advance)
        begin
            result_reg <= filtered;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.filtered_x = result_reg[0];
    assign results.filtered_y = result_reg[1];
    assign results.filtered_z = result_reg[2];

`ifndef NO_ASSERTIONS
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input stage lost a sample while the result stage was full");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |-> !samples.ready)
        else $error("sample accepted while the input stage could not drain");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("computed result was not presented");

    a_primed_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> primed_reg)
        else $error("filter not primed after its first sample");
`endif

endmodule

// ===== sim/three_axis_second_order_iir_lowpass_top_test.sv =====
`timescale 1ns / 1ps

module three_axis_second_order_iir_lowpass_top_test;

    import tsiir_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_ITEMS = 120;
    localparam int PHASE_COUNT = 7;
    localparam int PHASE_ITEMS = 148;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic signed [65:0] ROUND_HALF = 66'sd536870912;
    localparam logic signed [65:0] Q16_MAX = 66'sd2147483647;
    localparam logic signed [65:0] Q16_MIN = -66'sd2147483648;

    localparam logic [31:0] EXTREME_COEFS [5] = '{
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h4000_0000, 32'hC000_0000
    };

    typedef enum logic {
        STEP_SAMPLE,
        STEP_COEF_WRITE
    } step_kind_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } raw_sample_t;

    typedef struct packed {
        q16_t x;
        q16_t y;
        q16_t z;
    } filtered_t;

    typedef struct {
        step_kind_t  kind;
        raw_sample_t sample;
        reg_index_t  index;
        logic [31:0] value;
    } step_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [COEF_WIDTH-1:0] cfg_data;

    tsiir_sample_if #(.SAMPLE_WIDTH(16)) samples ();
    tsiir_result_if results ();

    three_axis_second_order_iir_lowpass_top #(
        .SAMPLE_WIDTH(16)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .samples(samples),
        .results(results),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    step_t     sample_plan[$];
    filtered_t pending_filtered[$];

    coef_t coef_model = '{fb_one: FB_ONE_RESET, fb_two: FB_TWO_RESET, gain: INPUT_RESET};
    logic  primed_model = 1'b0;
    q16_t  last_out [AXES] = '{default: '0};
    q16_t  prior_out [AXES] = '{default: '0};

    int   error_count = 0;
    int   idle_cycles = 0;
    int   send_gap = 0;
    int   take_gap = 0;
    int   settle = 0;
    logic sample_taken = 1'b0;

    always #1 clk = ~clk;

    function automatic q16_t iir_axis(input q16_t last, input q16_t prior, input q16_t xq);
        logic signed [65:0] acc;
        acc = 66'($signed(last)) * 66'($signed(coef_model.fb_one))
            + 66'($signed(prior)) * 66'($signed(coef_model.fb_two))
            + 66'($signed(xq)) * 66'($signed(coef_model.gain));
        acc = (acc + ROUND_HALF) >>> 30;
        if (acc > Q16_MAX)
        begin
            return Q16_MAX[31:0];
        end
        if (acc < Q16_MIN)
        begin
            return Q16_MIN[31:0];
        end
        return acc[31:0];
    endfunction

    function automatic filtered_t filter_step(input raw_sample_t s);
        logic signed [15:0] raw [AXES];
        q16_t               y [AXES];
        q16_t               xq;
        filtered_t          r;
        raw[0] = s.x;
        raw[1] = s.y;
        raw[2] = s.z;
        for (int a = 0; a < AXES; a++)
        begin
            xq = {raw[a], 16'h0000};
            if (!primed_model)
            begin
                y[a] = xq;
                prior_out[a] = xq;
                last_out[a] = xq;
            end
            else
            begin
                y[a] = iir_axis(last_out[a], prior_out[a], xq);
                prior_out[a] = last_out[a];
                last_out[a] = y[a];
            end
        end
        primed_model = 1'b1;
        r.x = y[0];
        r.y = y[1];
        r.z = y[2];
        return r;
    endfunction

    task automatic check_axis(input string axis, input q16_t want, input q16_t got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, axis, want, got);
            error_count++;
        end
    endtask

    task automatic plan_sample(input int x, input int y, input int z);
        step_t s;
        s.kind = STEP_SAMPLE;
        s.sample.x = 16'(x);
        s.sample.y = 16'(y);
        s.sample.z = 16'(z);
        s.index = REG_FB_ONE;
        s.value = '0;
        sample_plan.push_back(s);
    endtask

    task automatic plan_write(input reg_index_t index, input logic [31:0] value);
        step_t s;
        s.kind = STEP_COEF_WRITE;
        s.sample = '0;
        s.index = index;
        s.value = value;
        sample_plan.push_back(s);
    endtask

    task automatic plan_coefs(input logic [31:0] fb_one, input logic [31:0] fb_two,
                              input logic [31:0] gain);
        plan_write(REG_FB_ONE, fb_one);
        plan_write(REG_FB_TWO, fb_two);
        plan_write(REG_INPUT, gain);
    endtask

    always @(negedge clk)
    begin
        step_t head;
        logic  next_valid;
        logic  next_write;
        if (rst_n)
        begin
            next_valid = samples.valid && !sample_taken;
            next_write = 1'b0;
            if (pending_filtered.size() == 0 && !next_valid)
            begin
                settle++;
            end
            else
            begin
                settle = 0;
            end
            if (!next_valid && sample_plan.size() > 0)
            begin
                head = sample_plan[0];
                if (head.kind == STEP_COEF_WRITE)
                begin
                    if (settle >= SETTLE_CYCLES)
                    begin
                        cfg_index <= head.index;
                        cfg_data <= head.value;
                        next_write = 1'b1;
                        void'(sample_plan.pop_front());
                    end
                end
                else if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (sample_plan.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0)
                begin
                    send_gap = $urandom_range(0, 12);
                end
                else
                begin
                    samples.sample_x <= head.sample.x;
                    samples.sample_y <= head.sample.y;
                    samples.sample_z <= head.sample.z;
                    next_valid = 1'b1;
                    void'(sample_plan.pop_front());
                end
            end
            samples.valid <= next_valid;
            cfg_write <= next_write;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (take_gap > 0)
            begin
                take_gap--;
                results.ready <= 1'b0;
            end
            else if (sample_plan.size() > TAIL_ITEMS && $urandom_range(0, 9) == 0)
            begin
                take_gap = $urandom_range(0, 12);
                results.ready <= 1'b0;
            end
            else
            begin
                results.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        raw_sample_t s;
        filtered_t   want;
        if (rst_n)
        begin
            sample_taken <= samples.valid && samples.ready;
            if (samples.valid && samples.ready)
            begin
                s.x = samples.sample_x;
                s.y = samples.sample_y;
                s.z = samples.sample_z;
                pending_filtered.push_back(filter_step(s));
            end
            if (results.valid && results.ready)
            begin
                if (pending_filtered.size() == 0)
                begin
                    $display("%0t: unexpected result transaction %0d %0d %0d", $time,
                             results.filtered_x, results.filtered_y, results.filtered_z);
                    error_count++;
                end
                else
                begin
                    want = pending_filtered.pop_front();
                    check_axis("filtered_x", want.x, results.filtered_x);
                    check_axis("filtered_y", want.y, results.filtered_y);
                    check_axis("filtered_z", want.z, results.filtered_z);
                end
            end
            if (cfg_write)
            begin
                case (reg_index_t'(cfg_index))
                    REG_FB_ONE: coef_model.fb_one = cfg_data;
                    REG_FB_TWO: coef_model.fb_two = cfg_data;
                    REG_INPUT:  coef_model.gain = cfg_data;
                    default:    ;
                endcase
            end
            if ((samples.valid && samples.ready) || (results.valid && results.ready)
                || cfg_write)
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int style;
        int seg;
        int lx;
        int ly;
        int lz;
        int n;
        logic [31:0] fb_one;
        logic [31:0] fb_two;
        logic [31:0] gain;

        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_FB_ONE;
        cfg_data = '0;
        samples.valid = 1'b0;
        samples.sample_x = '0;
        samples.sample_y = '0;
        samples.sample_z = '0;
        results.ready = 1'b0;

        // The first sample primes the history and passes through unchanged.
        plan_sample(-32768, 32767, 0);
        plan_sample(32767, -32768, 1);
        plan_sample(0, 0, 0);
        plan_sample(-1, 1, 12345);
        plan_sample(32767, 32767, 32767);
        plan_sample(-32768, -32768, -32768);

        // Largest and smallest coefficients drive the sums into saturation.
        plan_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        plan_sample(32767, -32768, 0);
        plan_sample(32767, -32768, 1);
        plan_sample(-32768, 32767, -1);
        plan_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        plan_sample(32767, -32768, 0);
        plan_sample(-32768, 32767, 0);
        plan_sample(1, -1, 0);

        // Unity input weight with no feedback, then half-LSB ties that round upward.
        plan_coefs(32'h0000_0000, 32'h0000_0000, 32'h4000_0000);
        plan_sample(32767, -32768, -1);
        plan_write(REG_INPUT, 32'd8192);
        plan_sample(1, -1, 3);
        plan_sample(-3, 32767, -32768);

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p % 4)
                0:
                begin
                    fb_one = FB_ONE_RESET;
                    fb_two = FB_TWO_RESET;
                    gain = INPUT_RESET;
                end
                1:
                begin
                    fb_one = 32'(int'($urandom_range(0, 966367640)) - 483183820);
                    fb_two = 32'(int'($urandom_range(0, 966367640)) - 483183820);
                    gain = 32'($urandom_range(0, 32'h1000_0000));
                end
                2:
                begin
                    fb_one = $urandom;
                    fb_two = $urandom;
                    gain = $urandom;
                end
                default:
                begin
                    fb_one = EXTREME_COEFS[$urandom_range(0, 4)];
                    fb_two = EXTREME_COEFS[$urandom_range(0, 4)];
                    gain = EXTREME_COEFS[$urandom_range(0, 4)];
                end
            endcase
            plan_coefs(fb_one, fb_two, gain);
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                style = $urandom_range(0, 3);
                seg = $urandom_range(4, 30);
                lx = int'($urandom_range(0, 65535)) - 32768;
                ly = int'($urandom_range(0, 65535)) - 32768;
                lz = int'($urandom_range(0, 65535)) - 32768;
                for (int k = 0; k < seg && n < PHASE_ITEMS; k++)
                begin
                    case (style)
                        0: plan_sample($urandom, $urandom, $urandom);
                        1: plan_sample(lx, ly, lz);
                        2: plan_sample(lx + int'($urandom_range(0, 63)) - 32,
                                       ly + int'($urandom_range(0, 63)) - 32,
                                       lz + int'($urandom_range(0, 63)) - 32);
                        default: plan_sample($urandom_range(0, 1) ? 32767 : -32768,
                                             $urandom_range(0, 1) ? 32767 : -32768,
                                             $urandom_range(0, 1) ? 32767 : -32768);
                    endcase
                    n++;
                end
            end
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (sample_plan.size() == 0 && !samples.valid && pending_filtered.size() == 0);
        repeat (8) @(posedge clk);
        if (error_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
